### sv/nscc_pkg.sv
// Shared types, constants and helper functions for the sentence capture block.
`default_nettype none
package nscc_pkg;

   localparam int TAG_BITS = 40;
   localparam int TAG_CHARS = 5;
   localparam logic [TAG_BITS-1:0] TAG_RESET = 40'h4750474741;
   localparam logic [7:0] MAX_SENTENCE = 8'd128;
   localparam logic [7:0] COUNT_MAX = 8'd255;
   localparam logic [7:0] HEADER_LEN = 8'd6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [2:0] ST_BUSY = 3'd0;
   localparam logic [2:0] ST_OK = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_FORMAT = 3'd3;
   localparam logic [2:0] ST_TRUNC = 3'd4;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam logic REG_TAG = 1'b0;

   typedef enum logic [3:0] {
      PH_BODY   = 4'b0001,
      PH_HEX_HI = 4'b0010,
      PH_HEX_LO = 4'b0100,
      PH_TAIL   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic       header;
      logic [7:0] data;
      logic       last;
      logic [2:0] status;
   } result_type;

   // Pick tag character idx (0 = first, in the top byte).
   function automatic logic [7:0] tag_char(input logic [TAG_BITS-1:0] tag,
                                           input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = tag[39:32];
         3'd1: c = tag[31:24];
         3'd2: c = tag[23:16];
         3'd3: c = tag[15:8];
         3'd4: c = tag[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Upper-case hex digit decode: {ok, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/nscc_csr.sv
// Configuration register file: the sentence tag behind a simple APB-style port.
`default_nettype none
module nscc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [nscc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [nscc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [nscc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output logic      [nscc_pkg::TAG_BITS-1:0]        tag
);

   logic [nscc_pkg::TAG_BITS-1:0] tag_ff;
   logic [nscc_pkg::TAG_BITS-1:0] tag_in;
   logic                          hit_tag;

   assign hit_tag = (csr_paddr[3] == nscc_pkg::REG_TAG);

   always_comb begin
      tag_in = tag_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_tag) begin
         tag_in = csr_pwdata[nscc_pkg::TAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= nscc_pkg::TAG_RESET;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit_tag ?
      {{(nscc_pkg::CSR_DATA_BITS-nscc_pkg::TAG_BITS){1'b0}}, tag_ff} :
      {nscc_pkg::CSR_DATA_BITS{1'b0}};
   assign tag = tag_ff;

endmodule
`default_nettype wire

### sv/nscc_parser.sv
// Input register, tag hunt and sentence checksum state machine.
`default_nettype none
module nscc_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   input  wire logic [nscc_pkg::TAG_BITS-1:0] tag,
   input  wire logic                          out_free,
   output nscc_pkg::result_type               res
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic [2:0]          pos_ff, pos_in;
   logic                active_ff, active_in;
   nscc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          rxchk_ff, rxchk_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic                derr_ff, derr_in;

   logic       has_result;
   logic       go;
   logic [7:0] b;
   logic [7:0] tag_xor;
   logic [4:0] hex;
   nscc_pkg::result_type r;

   assign b = in_byte_ff;

   always_comb begin
      tag_xor = 8'h00;
      for (int k = 0; k < nscc_pkg::TAG_CHARS; k++) begin
         tag_xor = tag_xor ^ nscc_pkg::tag_char(tag, 3'(k));
      end
   end

   assign hex = nscc_pkg::hex_decode(b);

   // Step logic for the byte held in the input register.
   always_comb begin
      pos_in = pos_ff;
      active_in = active_ff;
      phase_in = phase_ff;
      xor_in = xor_ff;
      rxchk_in = rxchk_ff;
      cnt_in = cnt_ff;
      derr_in = derr_ff;
      has_result = 1'b0;
      r = '0;
      r.data = b;
      r.status = nscc_pkg::ST_BUSY;
      if (!active_ff) begin
         if (pos_ff == 3'd0) begin
            if (b == nscc_pkg::CH_DOLLAR) begin
               pos_in = 3'd1;
            end
         end else if (pos_ff > 3'd5 || b != nscc_pkg::tag_char(tag, pos_ff - 3'd1)) begin
            pos_in = (b == nscc_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
         end else if (pos_ff < 3'd5) begin
            pos_in = pos_ff + 3'd1;
         end else begin
            pos_in = 3'd0;
            active_in = 1'b1;
            phase_in = nscc_pkg::PH_BODY;
            rxchk_in = 8'h00;
            derr_in = 1'b0;
            xor_in = tag_xor;
            cnt_in = nscc_pkg::HEADER_LEN;
            has_result = 1'b1;
            r.header = 1'b1;
            r.data = nscc_pkg::CH_DOLLAR;
         end
      end else begin
         has_result = 1'b1;
         if (cnt_ff < nscc_pkg::COUNT_MAX) begin
            cnt_in = cnt_ff + 8'd1;
         end
         if (b == nscc_pkg::CH_NL) begin
            r.last = 1'b1;
            if (phase_ff != nscc_pkg::PH_TAIL || derr_ff) begin
               r.status = nscc_pkg::ST_FORMAT;
            end else if (rxchk_ff == xor_ff) begin
               r.status = nscc_pkg::ST_OK;
            end else begin
               r.status = nscc_pkg::ST_MISMATCH;
            end
            active_in = 1'b0;
            pos_in = 3'd0;
         end else begin
            case (phase_ff)
               nscc_pkg::PH_BODY: begin
                  if (b == nscc_pkg::CH_STAR) begin
                     phase_in = nscc_pkg::PH_HEX_HI;
                  end else begin
                     xor_in = xor_ff ^ b;
                  end
               end
               nscc_pkg::PH_HEX_HI, nscc_pkg::PH_HEX_LO: begin
                  if (!hex[4]) begin
                     derr_in = 1'b1;
                  end
                  rxchk_in = {rxchk_ff[3:0], hex[3:0]};
                  phase_in = (phase_ff == nscc_pkg::PH_HEX_HI) ?
                             nscc_pkg::PH_HEX_LO : nscc_pkg::PH_TAIL;
               end
               default: begin
                  if (b != nscc_pkg::CH_CR) begin
                     derr_in = 1'b1;
                  end
               end
            endcase
            if (cnt_in >= nscc_pkg::MAX_SENTENCE) begin
               r.last = 1'b1;
               r.status = nscc_pkg::ST_TRUNC;
               active_in = 1'b0;
               pos_in = 3'd0;
            end
         end
      end
   end

   // Advance when the byte makes no beat or the result register can take one.
   assign go = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || go;

   always_comb begin
      res = r;
      res.valid = go && has_result;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff <= 3'd0;
         active_ff <= 1'b0;
         phase_ff <= nscc_pkg::PH_BODY;
         xor_ff <= 8'h00;
         rxchk_ff <= 8'h00;
         cnt_ff <= 8'h00;
         derr_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (go) begin
            pos_ff <= pos_in;
            active_ff <= active_in;
            phase_ff <= phase_in;
            xor_ff <= xor_in;
            rxchk_ff <= rxchk_in;
            cnt_ff <= cnt_in;
            derr_ff <= derr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

endmodule
`default_nettype wire

### sv/nscc_out.sv
// Result register with the header burst sequencer.
`default_nettype none
module nscc_out (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nscc_pkg::result_type          res,
   input  wire logic [nscc_pkg::TAG_BITS-1:0] tag,
   output logic                               out_free,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata,
   output logic                               rsp_tlast,
   output logic [2:0]                         rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [2:0] status_ff, status_in;
   logic [2:0] left_ff, left_in;
   logic       burst;

   assign burst = (left_ff != 3'd0);
   assign out_free = !valid_ff || (rsp_tready && !burst);

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      last_in = last_ff;
      status_in = status_ff;
      left_in = left_ff;
      if (valid_ff && rsp_tready && burst) begin
         // Step through the tag characters behind the dollar.
         data_in = nscc_pkg::tag_char(tag, 3'(nscc_pkg::TAG_CHARS) - left_ff);
         left_in = left_ff - 3'd1;
      end else if (res.valid) begin
         valid_in = 1'b1;
         data_in = res.data;
         last_in = res.last;
         status_in = res.status;
         left_in = res.header ? 3'(nscc_pkg::TAG_CHARS) : 3'd0;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tuser = status_ff;

endmodule
`default_nettype wire

### sv/nmea_sentence_capture_check_core.sv
// NMEA sentence capture core: tag hunt, pass-through and checksum verdict.
// Path: an accepted byte passes the input register and then the result register.
// Throughput: one byte per cycle while the result register is free; the byte that
// completes the header yields six beats, and input waits until the last one is taken.
// Reset (synchronous, active high) clears all control state and loads the tag "GPGGA".
// No clearing pass: the block takes bytes as soon as reset is released.
`default_nettype none
module nmea_sentence_capture_check_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Receive byte stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] rx_byte
   // Captured sentence beats
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [7:0]                              rsp_tdata,   // [7:0] out_byte
   output logic                                    rsp_tlast,   // is_last
   output logic [2:0]                              rsp_tuser,   // [2:0] status
   // Configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [nscc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [nscc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [nscc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                    csr_pready
);

   logic [nscc_pkg::TAG_BITS-1:0] tag;
   logic                          out_free;
   nscc_pkg::result_type          res;

   // Tag register; the user must change it only while no sentence is in flight (not enforced).
   nscc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tag         (tag)
   );

   // Input register plus the hunt/check state; advance one byte per cycle
   // whenever the byte makes no beat or the result register is free.
   nscc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .tag        (tag),
      .out_free   (out_free),
      .res        (res)
   );

   // Result register; on a header it plays out '$' then the five tag characters.
   nscc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .tag        (tag),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A beat is only produced when the result register can take it.
   a_res_fits: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> out_free)
      else $error("result produced while result register busy");

   // A header always starts with the dollar beat.
   a_hdr_dollar: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.header) |=> (rsp_tvalid && rsp_tdata == nscc_pkg::CH_DOLLAR
                                     && !rsp_tlast))
      else $error("header burst did not start with dollar");

   // Verdicts travel only on the final beat, and every final beat has one.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != nscc_pkg::ST_BUSY)))
      else $error("status and last flag disagree");

endmodule
`default_nettype wire
